@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the keypad code lock checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/kclc_pkg.sv @@
// ----------------------------------------------------------------------------
// kclc_pkg
// Types, codes and constants of the keypad code lock controller.
// ----------------------------------------------------------------------------
package kclc_pkg;

   localparam int CODE_DIGITS = 4;
   // entry index runs 0 .. CODE_DIGITS+1 (the top value marks overflow)
   localparam int IDX_W       = $clog2(CODE_DIGITS + 2);
   localparam int KEY_W       = 4;
   localparam int EV_W        = 3;
   localparam int CNT_W       = 8;

   localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd10;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 4'd11;
   localparam logic [KEY_W-1:0] KEY_NONE   = 4'd12;
   localparam logic [KEY_W-1:0] KEY_LONG   = 4'd13;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd40;
   localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;

   localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
   localparam logic [EV_W-1:0] EV_UNLOCKED  = 3'd1;
   localparam logic [EV_W-1:0] EV_LOCKED    = 3'd2;
   localparam logic [EV_W-1:0] EV_ERROR     = 3'd3;
   localparam logic [EV_W-1:0] EV_CHANGED   = 3'd4;
   localparam logic [EV_W-1:0] EV_CANCELLED = 3'd5;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_MENU   = 2'd1,
      MODE_ENTRY  = 2'd2,
      MODE_CHANGE = 2'd3
   } mode_type;

   // factory code 2,5,8,0; further slots zero
   function automatic logic [KEY_W-1:0] reset_digit(input int slot);
      logic [KEY_W-1:0] d;
      case (slot)
         0: begin
            d = 4'd2;
         end
         1: begin
            d = 4'd5;
         end
         2: begin
            d = 4'd8;
         end
         default: begin
            d = 4'd0;
         end
      endcase
      return d;
   endfunction

endpackage

@@ hdl/keypad_code_lock_controller.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Keypad code lock: menu, code entry and code change driven by scan samples.
// ----------------------------------------------------------------------------
// Response is registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless a response stalls; one-pass update.
// The response register frees up as it is taken, so requests keep flowing.
// Reset (synchronous, active high): lock closed, mode off, factory code,
// long-press limit 40, response register empty.
module keypad_code_lock_controller (
   input  logic        clock,
   input  logic        reset,
   // configuration: long_press_limit
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] key, [7:4] zero
   input  logic        req_tuser,   // kind: 0 scan sample, 1 enter menu
   // responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] is_locked, [3:1] event_res, [5:4] mode,
                                    // [6] input_led, [7] change_led,
                                    // [8] keypad_led, [15:9] zero
);
   import kclc_pkg::*;

   // control state
   mode_type         mode_ff,     mode_in;
   logic             pending_ff,  pending_in;
   logic [KEY_W-1:0] held_ff,     held_in;
   logic [CNT_W-1:0] hold_cnt_ff, hold_cnt_in;
   logic [IDX_W-1:0] idx_ff,      idx_in;
   logic             locked_ff,   locked_in;
   logic             lamp_ff,     lamp_in;
   logic [CNT_W-1:0] limit_ff,    limit_in;

   // entry buffer and stored code
   logic [KEY_W-1:0]       digit_ff  [CODE_DIGITS];
   logic [KEY_W-1:0]       digit_in  [CODE_DIGITS];
   logic [CODE_DIGITS-1:0] filled_ff, filled_in;
   logic [KEY_W-1:0]       code_ff   [CODE_DIGITS];
   logic [KEY_W-1:0]       code_in   [CODE_DIGITS];

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff,  rsp_data_in;

   logic             accept;
   logic [KEY_W-1:0] key;
   logic [EV_W-1:0]  ev;
   logic             match;
   logic             complete;

   // a request may enter while the response register drains
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign key        = req_tdata[KEY_W-1:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // unentered slots read as zero, so a short entry compares as if padded with zeros
   always_comb begin
      match    = (idx_ff <= IDX_W'(CODE_DIGITS));
      complete = (idx_ff <= IDX_W'(CODE_DIGITS)) && (&filled_ff);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (digit_ff[i] != code_ff[i]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pending_in  = pending_ff;
      held_in     = held_ff;
      hold_cnt_in = hold_cnt_ff;
      idx_in      = idx_ff;
      locked_in   = locked_ff;
      lamp_in     = lamp_ff;
      filled_in   = filled_ff;
      digit_in    = digit_ff;
      code_in     = code_ff;
      ev          = EV_NONE;

      limit_in = csr_we ? csr_wdata : limit_ff;

      if (accept) begin
         if (req_tuser) begin
            // menu request only wakes the lock from off
            if (mode_ff == MODE_OFF) begin
               mode_in = MODE_MENU;
            end
         end else begin
            case (mode_ff)
               MODE_MENU: begin
                  if (key == KEY_NONE) begin
                     // release: act on the held key
                     if (pending_ff) begin
                        if (held_ff == KEY_CANCEL) begin
                           mode_in = MODE_OFF;
                        end else if (held_ff == KEY_ENTER) begin
                           if (!locked_ff) begin
                              locked_in = 1'b1;
                              ev        = EV_LOCKED;
                           end else begin
                              mode_in = MODE_ENTRY;
                           end
                        end else if (held_ff == KEY_LONG) begin
                           hold_cnt_in = '0;
                           mode_in     = MODE_CHANGE;
                           filled_in   = '0;
                        end
                        held_in    = KEY_NONE;
                        pending_in = 1'b0;
                     end
                  end else if (key == KEY_CANCEL) begin
                     // hold count adds up across presses until a change starts
                     if (pending_ff && (hold_cnt_ff > limit_ff)) begin
                        lamp_in = 1'b1;
                        held_in = KEY_LONG;
                     end else begin
                        if (pending_ff && (hold_cnt_ff != CNT_MAX)) begin
                           hold_cnt_in = hold_cnt_ff + CNT_W'(1);
                        end
                        held_in    = KEY_CANCEL;
                        pending_in = 1'b1;
                     end
                  end else if (key == KEY_ENTER) begin
                     held_in    = KEY_ENTER;
                     pending_in = 1'b1;
                  end
               end
               MODE_ENTRY, MODE_CHANGE: begin
                  if (key != KEY_NONE) begin
                     held_in    = key;
                     pending_in = 1'b1;
                  end else if (pending_ff) begin
                     if (held_ff == KEY_CANCEL || held_ff == KEY_ENTER) begin
                        if (held_ff == KEY_CANCEL) begin
                           ev = EV_CANCELLED;
                        end else if (mode_ff == MODE_ENTRY) begin
                           if (match) begin
                              locked_in = 1'b0;
                              ev        = EV_UNLOCKED;
                           end else begin
                              ev = EV_ERROR;
                           end
                        end else begin
                           if (complete) begin
                              code_in = digit_ff;
                              ev      = EV_CHANGED;
                           end else begin
                              ev = EV_ERROR;
                           end
                        end
                        // back to menu with a clean entry
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                           digit_in[i] = '0;
                        end
                        filled_in  = '0;
                        idx_in     = '0;
                        lamp_in    = 1'b0;
                        mode_in    = MODE_MENU;
                        pending_in = 1'b0;
                        held_in    = KEY_NONE;
                     end else if (idx_ff >= IDX_W'(CODE_DIGITS)) begin
                        // overflow: key stays pending, so repeats change nothing
                        idx_in = IDX_W'(CODE_DIGITS + 1);
                     end else begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                           if (idx_ff == IDX_W'(i)) begin
                              digit_in[i]  = held_ff;
                              filled_in[i] = 1'b1;
                           end
                        end
                        idx_in     = idx_ff + IDX_W'(1);
                        held_in    = KEY_NONE;
                        pending_in = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // response slot
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (accept) begin
         rsp_data_in = {7'd0,
                        (mode_in != MODE_OFF),
                        lamp_in,
                        (mode_in == MODE_ENTRY),
                        mode_in,
                        ev,
                        locked_in};
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         pending_ff   <= 1'b0;
         held_ff      <= KEY_NONE;
         hold_cnt_ff  <= '0;
         idx_ff       <= '0;
         locked_ff    <= 1'b1;
         lamp_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            digit_ff[i] <= '0;
            code_ff[i]  <= reset_digit(i);
         end
      end else begin
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         hold_cnt_ff  <= hold_cnt_in;
         idx_ff       <= idx_in;
         locked_ff    <= locked_in;
         lamp_ff      <= lamp_in;
         limit_ff     <= limit_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
         digit_ff     <= digit_in;
         code_ff      <= code_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/kclc_checker.sv @@
// ----------------------------------------------------------------------------
// kclc_checker
// Port-level checks on the keypad code lock controller, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kclc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import kclc_pkg::*;

   // stalled response holds its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no request enters while a stalled response fills the register
   `ASSERT_IMPL(a_no_overrun, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // entry lamp follows code entry mode
   `ASSERT_IMPL(a_entry_led, clock, reset, rsp_tvalid, rsp_tdata[6] == (rsp_tdata[5:4] == MODE_ENTRY))

   // keypad lamp lit in every mode but off
   `ASSERT_IMPL(a_keypad_led, clock, reset, rsp_tvalid, rsp_tdata[8] == (rsp_tdata[5:4] != MODE_OFF))

   // response register comes out of reset empty
   `ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/kclc_lock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kclc_lock_checker
// Watches the request, response and register ports of the keypad code lock,
// keeps its own copy of the lock state, works out the status each request
// should produce and compares it with the response, oldest first.
// ----------------------------------------------------------------------------
module kclc_lock_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          mismatches,
   output int          awaiting
);
   import kclc_pkg::*;

   // response word, top bits first
   typedef struct packed {
      logic [6:0]      pad;
      logic            keypad_led;
      logic            change_led;
      logic            input_led;
      mode_type        mode;
      logic [EV_W-1:0] event_res;
      logic            is_locked;
   } lock_status_t;

   // factory code, slot 0 in the low nibble
   localparam logic [31:0] FACTORY_CODE = 32'h0000_0852;

   logic [CNT_W-1:0] press_limit;
   mode_type         lock_mode;
   logic             key_armed;
   logic [KEY_W-1:0] last_key;
   logic [CNT_W-1:0] cancel_count;
   logic [KEY_W-1:0] typed [CODE_DIGITS];
   logic             typed_ok [CODE_DIGITS];
   logic [IDX_W-1:0] type_pos;
   logic [KEY_W-1:0] door_code [CODE_DIGITS];
   logic             bolt_locked;
   logic             change_lamp;

   lock_status_t     status_due [$];
   int               fail_total = 0;

   function automatic void wipe_entry();
      for (int i = 0; i < CODE_DIGITS; i++) begin
         typed[i]    = '0;
         typed_ok[i] = 1'b0;
      end
      type_pos    = '0;
      change_lamp = 1'b0;
   endfunction

   // one scan sample or menu request; returns the status seen after it
   function automatic lock_status_t advance_lock(input logic menu_req,
                                                 input logic [KEY_W-1:0] k);
      logic [EV_W-1:0] ev;
      logic            to_menu;
      logic            hit;
      logic            full;
      lock_status_t    s;
      ev      = EV_NONE;
      to_menu = 1'b0;
      if (menu_req) begin
         if (lock_mode == MODE_OFF) begin
            lock_mode = MODE_MENU;
         end
      end else if (lock_mode == MODE_MENU) begin
         if (k == KEY_NONE) begin
            if (key_armed) begin
               case (last_key)
                  KEY_CANCEL: begin
                     lock_mode = MODE_OFF;
                  end
                  KEY_ENTER: begin
                     if (!bolt_locked) begin
                        bolt_locked = 1'b1;
                        ev          = EV_LOCKED;
                     end else begin
                        lock_mode = MODE_ENTRY;
                     end
                  end
                  KEY_LONG: begin
                     cancel_count = '0;
                     lock_mode    = MODE_CHANGE;
                     for (int i = 0; i < CODE_DIGITS; i++) begin
                        typed_ok[i] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
               last_key  = KEY_NONE;
               key_armed = 1'b0;
            end
         end else if (k == KEY_CANCEL) begin
            if (key_armed && cancel_count > press_limit) begin
               change_lamp = 1'b1;
               last_key    = KEY_LONG;
            end else begin
               if (key_armed && cancel_count != CNT_MAX) begin
                  cancel_count = cancel_count + CNT_W'(1);
               end
               last_key  = KEY_CANCEL;
               key_armed = 1'b1;
            end
         end else if (k == KEY_ENTER) begin
            last_key  = KEY_ENTER;
            key_armed = 1'b1;
         end
         if (lock_mode == MODE_OFF) begin
            key_armed = 1'b0;
            last_key  = KEY_NONE;
         end
      end else if (lock_mode != MODE_OFF) begin
         if (k != KEY_NONE) begin
            last_key  = k;
            key_armed = 1'b1;
         end else if (key_armed) begin
            if (last_key == KEY_CANCEL) begin
               ev      = EV_CANCELLED;
               to_menu = 1'b1;
            end else if (last_key == KEY_ENTER) begin
               hit  = (type_pos <= IDX_W'(CODE_DIGITS));
               full = hit;
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  if (typed[i] != door_code[i]) hit = 1'b0;
                  if (!typed_ok[i]) full = 1'b0;
               end
               if (lock_mode == MODE_ENTRY) begin
                  if (hit) begin
                     bolt_locked = 1'b0;
                     ev          = EV_UNLOCKED;
                  end else begin
                     ev = EV_ERROR;
                  end
               end else if (full) begin
                  door_code = typed;
                  ev        = EV_CHANGED;
               end else begin
                  ev = EV_ERROR;
               end
               to_menu = 1'b1;
            end else if (type_pos >= IDX_W'(CODE_DIGITS)) begin
               // overflow: key stays pending
               type_pos = IDX_W'(CODE_DIGITS + 1);
            end else begin
               typed[type_pos]    = last_key;
               typed_ok[type_pos] = 1'b1;
               type_pos           = type_pos + IDX_W'(1);
               last_key           = KEY_NONE;
               key_armed          = 1'b0;
            end
         end
      end
      if (to_menu) begin
         wipe_entry();
         lock_mode = MODE_MENU;
         key_armed = 1'b0;
         last_key  = KEY_NONE;
      end
      s            = '0;
      s.is_locked  = bolt_locked;
      s.event_res  = ev;
      s.mode       = lock_mode;
      s.input_led  = (lock_mode == MODE_ENTRY);
      s.change_led = change_lamp;
      s.keypad_led = (lock_mode != MODE_OFF);
      return s;
   endfunction

   always @(posedge clock) begin
      lock_status_t got;
      lock_status_t want;
      if (reset) begin
         press_limit  = LIMIT_RESET;
         lock_mode    = MODE_OFF;
         key_armed    = 1'b0;
         last_key     = KEY_NONE;
         cancel_count = '0;
         bolt_locked  = 1'b1;
         wipe_entry();
         for (int i = 0; i < CODE_DIGITS; i++) begin
            door_code[i] = (i < 8) ? FACTORY_CODE[4*i +: 4] : '0;
         end
         status_due.delete();
      end else begin
         if (csr_we) begin
            press_limit = csr_wdata;
         end
         // response first: it belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got = lock_status_t'(rsp_tdata);
            if (status_due.size() == 0) begin
               fail_total++;
               if (fail_total <= 10) begin
                  $display("%0t: response %h with no request outstanding", $realtime,
                           rsp_tdata);
               end
            end else begin
               want = status_due.pop_front();
               if (got.is_locked !== want.is_locked || got.event_res !== want.event_res ||
                   got.mode !== want.mode || got.input_led !== want.input_led ||
                   got.change_led !== want.change_led ||
                   got.keypad_led !== want.keypad_led || got.pad !== want.pad) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("%0t: status mismatch (locked ev mode in chg kp pad)", $realtime);
                     $display("   expected %0d %0d %0d %0d %0d %0d %h", want.is_locked,
                              want.event_res, want.mode, want.input_led, want.change_led,
                              want.keypad_led, want.pad);
                     $display("   actual   %0d %0d %0d %0d %0d %0d %h", got.is_locked,
                              got.event_res, got.mode, got.input_led, got.change_led,
                              got.keypad_led, got.pad);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            status_due.push_back(advance_lock(req_tuser, req_tdata[KEY_W-1:0]));
         end
      end
      mismatches <= fail_total;
      awaiting   <= status_due.size();
   end

endmodule

@@ tb/tb_keypad_code_lock_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_controller
// Drives keypad scan samples and menu requests into the code lock: a short
// directed opening, then phases of keypad sessions (unlock tries, long-press
// code changes, quits and noise) under several long-press limits and
// idle/stall patterns. A separate checker predicts and compares responses.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_controller;
   import kclc_pkg::*;

   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
   localparam int PHASE_REQS  = 350;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [3:0] key, [7:4] zero
   logic        req_tuser  = 1'b0;   // kind: 0 scan sample, 1 enter menu
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [0] locked, [3:1] event, [5:4] mode,
                                     // [6] input, [7] change, [8] keypad led

   int mismatches;
   int awaiting;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int sent_total     = 0;     // requests accepted so far
   int quiet_cycles   = 0;
   int cur_limit      = 40;    // long-press limit as last written

   // best guess of the stored code, only used to steer unlock tries
   logic [KEY_W-1:0] code_guess [CODE_DIGITS];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keypad_code_lock_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   kclc_lock_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: stuck handshakes end the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // one request; random idle cycles ahead of it, then wait for acceptance
   task automatic send_req(input logic menu_req, input logic [KEY_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= menu_req;
      req_tdata  <= {4'd0, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_total++;
   endtask

   // key held for a number of scans, then released for one or two
   task automatic tap(input logic [KEY_W-1:0] k, input int holds);
      repeat (holds) send_req(1'b0, k);
      repeat ($urandom_range(2, 1)) send_req(1'b0, KEY_NONE);
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   task automatic set_limit(input logic [7:0] v);
      drain();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_limit = v;
   endtask

   // mostly decimal digits, now and then one of the unused codes 13-15
   function automatic logic [KEY_W-1:0] any_digit();
      if ($urandom_range(19) == 0) begin
         return KEY_W'($urandom_range(15, 13));
      end
      return KEY_W'($urandom_range(9));
   endfunction

   // a phase of keypad sessions; first_hold > 0 opens with one long cancel
   task automatic run_phase(input int reqs, input int idle, input int stall,
                            input int first_hold);
      int               stop_at;
      int               pause_at;
      int               n;
      logic [KEY_W-1:0] fresh [CODE_DIGITS];
      logic             settled;
      logic             right;
      logic             confirm;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      stop_at  = sent_total + reqs;
      pause_at = sent_total + reqs / 2;
      // menu request, cancel tap, menu request: lands in menu, nothing pending
      send_req(1'b1, KEY_W'($urandom_range(15)));
      tap(KEY_CANCEL, 1);
      send_req(1'b1, KEY_W'($urandom_range(15)));
      if (first_hold > 0) begin
         tap(KEY_CANCEL, first_hold);
      end
      while (sent_total < stop_at) begin
         if (pause_at > 0 && sent_total >= pause_at) begin
            drain();    // sender holds off until the pipe is empty
            pause_at = 0;
         end
         settled = ($urandom_range(9) < 7);
         if (settled) begin
            send_req(1'b1, KEY_W'($urandom_range(15)));
            tap(KEY_CANCEL, 1);
         end
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               // unlock try: enter, digits (often the right ones), enter
               send_req(1'b1, KEY_W'($urandom_range(15)));
               tap(KEY_ENTER, $urandom_range(3, 1));
               right = ($urandom_range(9) < 6);
               n = ($urandom_range(3) == 0) ? $urandom_range(CODE_DIGITS + 2) : CODE_DIGITS;
               for (int i = 0; i < n; i++) begin
                  tap((right && i < CODE_DIGITS) ? code_guess[i] : any_digit(),
                      $urandom_range(3, 1));
               end
               tap(($urandom_range(9) == 0) ? KEY_CANCEL : KEY_ENTER, $urandom_range(2, 1));
            end
            4, 5, 6: begin
               // code change: long cancel, new digits, enter
               send_req(1'b1, KEY_W'($urandom_range(15)));
               settled = settled && (cur_limit <= 60);
               tap(KEY_CANCEL, settled ? cur_limit + 3 + $urandom_range(2)
                                       : $urandom_range(20, 1));
               n = ($urandom_range(3) == 0) ? $urandom_range(CODE_DIGITS + 2) : CODE_DIGITS;
               for (int i = 0; i < CODE_DIGITS; i++) begin
                  fresh[i] = any_digit();
               end
               for (int i = 0; i < n; i++) begin
                  tap((i < CODE_DIGITS) ? fresh[i] : any_digit(), $urandom_range(3, 1));
               end
               confirm = ($urandom_range(9) != 0);
               tap(confirm ? KEY_ENTER : KEY_CANCEL, $urandom_range(2, 1));
               if (settled && confirm && n == CODE_DIGITS) begin
                  code_guess = fresh;
               end
            end
            7: begin
               // short cancel: leaves menu mode, or arms a change once counted up
               send_req(1'b1, KEY_W'($urandom_range(15)));
               tap(KEY_CANCEL, $urandom_range(3, 1));
            end
            default: begin
               // noise: any kind, any key code
               repeat ($urandom_range(15, 5)) begin
                  send_req($urandom_range(9) == 0, KEY_W'($urandom_range(15)));
               end
            end
         endcase
      end
   endtask

   initial begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
         code_guess[i] = reset_digit(i);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opening, reset limit, no idling
      send_req(1'b0, 4'd5);          // scan while off: ignored
      send_req(1'b1, KEY_ENTER);     // into menu, key field ignored
      send_req(1'b1, 4'd0);          // menu request while active: ignored
      tap(4'd3, 1);                  // digit in menu: ignored
      tap(KEY_ENTER, 1);             // locked, so code entry starts
      for (int i = 0; i < CODE_DIGITS; i++) begin
         tap(code_guess[i], 1);
      end
      tap(KEY_ENTER, 1);             // factory code: unlocked
      tap(KEY_ENTER, 1);             // open door: locked again
      tap(KEY_ENTER, 1);             // code entry
      tap(4'd15, 1);                 // unused code taken as a digit
      tap(KEY_CANCEL, 1);            // entry cancelled

      run_phase(PHASE_REQS, 0, 0, 0);
      set_limit(8'd0);
      run_phase(PHASE_REQS, 65, 0, 0);
      // top limit: a long cancel hold saturates the count without arming
      set_limit(8'd255);
      run_phase(PHASE_REQS, 0, 65, 260);
      set_limit(8'd3);
      run_phase(PHASE_REQS, 16, 16, 0);
      set_limit(8'($urandom_range(60, 4)));
      run_phase(PHASE_REQS, $urandom_range(40), $urandom_range(40), 0);

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/kclc_pkg.sv
hdl/keypad_code_lock_controller.sv
hdl/kclc_checker.sv
tb/kclc_lock_checker.sv
tb/tb_keypad_code_lock_controller.sv
